@@ src/dpsq_pkg.sv @@
package dpsq_pkg;

    localparam int CAPACITY_DEF    = 128;
    localparam int MEDIA_LIMIT_DEF = 100;

    localparam logic [1:0] CMD_GENERIC = 2'd0;
    localparam logic [1:0] CMD_MEDIA   = 2'd1;
    localparam logic [1:0] CMD_REPORT  = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [2:0] ST_ENQ      = 3'd0;
    localparam logic [2:0] ST_ENQ_DROP = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_PROGRESS = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;
    localparam logic [2:0] ST_FAIL     = 3'd7;

    localparam logic [0:0] REG_LINK_OPEN  = 1'd0;
    localparam logic [0:0] REG_MEDIA_MODE = 1'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] packet_handle;
        logic [23:0] packet_length;
        logic        droppable;
        logic        cfg_pkt;
        logic        key_pkt;
        logic [7:0]  depth_limit;
        logic [23:0] sent_bytes;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] head_handle;
        logic [23:0] head_length;
        logic [23:0] head_offset;
        logic [7:0]  queue_count;
        logic [7:0]  evicted_count;
    } out_word_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [23:0] length;
        logic        drop;
    } entry_t;

    // per-cycle command to the cell row
    typedef struct packed {
        logic   remove;   // close the gap at rm_pos
        logic   append;   // write app_entry at the count position
        entry_t app_entry;
    } row_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_APPEND,
        S_REPLY
    } state_t;

endpackage

@@ src/dpsq_cell.sv @@
module dpsq_cell
    import dpsq_pkg::*;
(
    input  logic   clk,
    input  logic   load,    // take the right neighbor's entry
    input  logic   write,   // take the new entry
    input  entry_t right,
    input  entry_t app,
    output entry_t q
);

    entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            q_reg <= app;
        end
        else if (load)
        begin
            q_reg <= right;
        end
    end

    assign q = q_reg;

endmodule

@@ src/dpsq_row.sv @@
module dpsq_row
    import dpsq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int PW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  logic            clk,
    input  row_ctl_t        ctl,
    input  logic [PW-1:0]   rm_pos,
    input  logic [CW-1:0]   count,
    output entry_t          head,
    output logic [CAPACITY-1:0] drop_map
);

    entry_t cell_q [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t right_w;
        logic   load_w;
        logic   write_w;

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_q[i];
        end
        else
        begin : g_mid
            assign right_w = cell_q[i+1];
        end

        assign load_w  = ctl.remove && (PW'(i) >= rm_pos);
        assign write_w = ctl.append && (count == CW'(i));

        dpsq_cell u_cell (
            .clk   (clk),
            .load  (load_w),
            .write (write_w),
            .right (right_w),
            .app   (ctl.app_entry),
            .q     (cell_q[i])
        );

        assign drop_map[i] = cell_q[i].drop;
    end

    assign head = cell_q[0];

endmodule

@@ src/droppable_packet_send_queue.sv @@
// channel | dir | signals                         | accepted when
// cmd     | in  | start, busy, in_word            | start && !busy
// result  | out | done, out_word                  | every cycle done is high
// config  | in  | psel penable pwrite paddr pwdata| psel && penable && pwrite
// Strobe follows accept directly for a drop or fail decided at once (incl. a
// media clear that drops), via S_APPEND for a media append, via S_EVICT for
// a non-empty send report or a generic word stopped at the eviction check,
// and via S_EVICT and S_APPEND for a generic append; each eviction is one
// shift of the cell row. busy stays high through the strobe cycle. Reset:
// queue empty, awaiting key frame, link closed, media off. Receiver can't stall.
module droppable_packet_send_queue
    import dpsq_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int MEDIA_LIMIT = MEDIA_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_word_t    in_word,
    output logic        done,
    output out_word_t   out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic link_reg, media_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg  <= 1'b0;
            media_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_LINK_OPEN)
            begin
                link_reg <= pwdata[0];
            end
            else
            begin
                media_reg <= pwdata[0];
            end
        end
    end
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            prdata[0] = (paddr[2] == REG_LINK_OPEN) ? link_reg : media_reg;
        end
    end

    state_t state_reg, state_next;
    in_word_t cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [23:0] sent_reg, sent_next;
    logic await_reg, await_next;
    logic [7:0] evict_reg, evict_next;
    logic [2:0] status_reg, status_next;
    logic [PW-1:0] rm_pos;
    row_ctl_t ctl;
    entry_t head;
    logic [CAPACITY-1:0] drop_map;

    dpsq_row #(.CAPACITY(CAPACITY)) u_row (
        .clk      (clk),
        .ctl      (ctl),
        .rm_pos   (rm_pos),
        .count    (count_reg),
        .head     (head),
        .drop_map (drop_map)
    );

    // oldest droppable entry below count, skipping a partly sent head
    logic          found;
    logic [PW-1:0] found_pos;
    always_comb
    begin
        found     = 1'b0;
        found_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (drop_map[i] && CW'(i) < count_reg && !(i == 0 && sent_reg != '0))
            begin
                found     = 1'b1;
                found_pos = PW'(i);
            end
        end
    end

    logic [24:0] total_sum;
    assign total_sum = {1'b0, sent_reg} + {1'b0, cmd_reg.sent_bytes};

    // compared at full width so neither limit is cut to the count's width
    logic at_limit;
    logic at_media_limit;
    assign at_limit       = 32'(count_reg) >= 32'(cmd_reg.depth_limit);
    assign at_media_limit = 32'(count_reg) >= 32'(MEDIA_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            sent_reg  <= '0;
            await_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sent_reg  <= sent_next;
            await_reg <= await_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        evict_reg  <= evict_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        sent_next   = sent_reg;
        await_next  = await_reg;
        evict_next  = evict_reg;
        status_next = status_reg;
        rm_pos      = found_pos;
        ctl         = '0;
        ctl.app_entry.handle = cmd_reg.packet_handle;
        ctl.app_entry.length = cmd_reg.packet_length;
        ctl.app_entry.drop   = (cmd_reg.command == CMD_GENERIC) ? cmd_reg.droppable : 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = in_word;
                    evict_next  = '0;
                    status_next = ST_DROPPED;
                    state_next  = S_REPLY;
                    if (in_word.command == CMD_GENERIC || in_word.command == CMD_MEDIA)
                    begin
                        if (in_word.packet_length != '0 && link_reg)
                        begin
                            if (in_word.command == CMD_GENERIC)
                            begin
                                if (in_word.depth_limit != '0)
                                begin
                                    state_next = S_EVICT;
                                end
                            end
                            else if (media_reg &&
                                     !(await_reg && !in_word.cfg_pkt && !in_word.key_pkt))
                            begin
                                state_next = S_APPEND;
                                if (at_media_limit)
                                begin
                                    evict_next  = 8'(count_reg);
                                    count_next  = '0;
                                    sent_next   = '0;
                                    await_next  = 1'b1;
                                    status_next = ST_ENQ_DROP;
                                    if (!in_word.cfg_pkt && !in_word.key_pkt)
                                    begin
                                        status_next = ST_DROPPED;
                                        state_next  = S_REPLY;
                                    end
                                end
                                else
                                begin
                                    status_next = ST_ENQ;
                                end
                                if (!in_word.cfg_pkt && in_word.key_pkt)
                                begin
                                    await_next = 1'b0;
                                end
                            end
                        end
                    end
                    else if (in_word.command == CMD_REPORT)
                    begin
                        if (!link_reg || (count_reg != '0 && in_word.sent_bytes == '0))
                        begin
                            status_next = ST_FAIL;
                        end
                        else if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            status_next = ST_PROGRESS;
                            state_next  = S_EVICT;
                        end
                    end
                end
            end
            S_EVICT:
            begin
                if (cmd_reg.command == CMD_REPORT)
                begin
                    state_next = S_REPLY;
                    if (total_sum >= {1'b0, head.length})
                    begin
                        rm_pos      = '0;
                        ctl.remove  = 1'b1;
                        count_next  = count_reg - 1'b1;
                        sent_next   = '0;
                        status_next = ST_DONE;
                    end
                    else
                    begin
                        sent_next = total_sum[23:0];
                    end
                end
                else if (at_limit && found)
                begin
                    ctl.remove = 1'b1;
                    count_next = count_reg - 1'b1;
                    evict_next = evict_reg + 1'b1;
                    if (found_pos == '0)
                    begin
                        sent_next = '0;
                    end
                end
                else if (at_limit && cmd_reg.droppable)
                begin
                    status_next = ST_DROPPED;
                    state_next  = S_REPLY;
                end
                else
                begin
                    status_next = (evict_reg != '0) ? ST_ENQ_DROP : ST_ENQ;
                    state_next  = S_APPEND;
                end
            end
            S_APPEND:
            begin
                state_next = S_REPLY;
                if (count_reg >= CW'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.append = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            S_REPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_REPLY);

    always_comb
    begin
        out_word               = '0;
        out_word.status        = status_reg;
        out_word.queue_count   = 8'(count_reg);
        out_word.evicted_count = evict_reg;
        if (count_reg != '0)
        begin
            out_word.head_handle = head.handle;
            out_word.head_length = head.length;
            out_word.head_offset = sent_reg;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("queue count beyond capacity");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_empty_offset: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> sent_reg == '0)
        else $error("offset set on empty queue");

endmodule

@@ test/dpsq_checker.sv @@
module dpsq_checker
    import dpsq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  in_word_t   in_word,
    input  logic       done,
    input  out_word_t  out_word,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output int         fail_count,
    output int         pending_count,
    output int         result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] handle;
        logic [23:0] length;
        logic        drop;
    } slot_t;

    slot_t       slots[$];
    logic [23:0] sent_so_far;
    logic        waiting_key;
    logic        link_up;
    logic        media_on;
    out_word_t   replies[$];

    assign pending_count = replies.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic void drop_slot(input int pos);
        slots.delete(pos);
        if (pos == 0)
            sent_so_far = '0;
    endfunction

    function automatic logic [2:0] queue_generic(input in_word_t w, inout int ev);
        int pick;
        while (slots.size() >= w.depth_limit)
        begin
            pick = -1;
            for (int i = (sent_so_far != 0) ? 1 : 0; i < slots.size(); i++)
                if (slots[i].drop)
                begin
                    pick = i;
                    break;
                end
            if (pick < 0)
            begin
                if (w.droppable)
                    return ST_DROPPED;
                break;
            end
            drop_slot(pick);
            ev++;
        end
        if (slots.size() >= CAPACITY_DEF)
            return ST_FULL;
        slots.insert(slots.size(), '{w.packet_handle, w.packet_length, w.droppable});
        return (ev > 0) ? ST_ENQ_DROP : ST_ENQ;
    endfunction

    function automatic logic [2:0] queue_media(input in_word_t w, inout int ev);
        logic cleared;
        cleared = 1'b0;
        if (!media_on)
            return ST_DROPPED;
        if (waiting_key && !w.cfg_pkt && !w.key_pkt)
            return ST_DROPPED;
        if (slots.size() >= MEDIA_LIMIT_DEF)
        begin
            ev = slots.size();
            slots.delete();
            sent_so_far = '0;
            waiting_key = 1'b1;
            cleared = 1'b1;
            if (!w.cfg_pkt && !w.key_pkt)
                return ST_DROPPED;
        end
        if (waiting_key && !w.cfg_pkt && w.key_pkt)
            waiting_key = 1'b0;
        if (slots.size() >= CAPACITY_DEF)
            return ST_FULL;
        slots.insert(slots.size(), '{w.packet_handle, w.packet_length, 1'b0});
        return cleared ? ST_ENQ_DROP : ST_ENQ;
    endfunction

    function automatic logic [2:0] take_report(input logic [23:0] n);
        logic [24:0] sum;
        if (slots.size() == 0)
            return ST_EMPTY;
        if (n == 0)
            return ST_FAIL;
        sum = sent_so_far + n;
        if (sum >= slots[0].length)
        begin
            drop_slot(0);
            return ST_DONE;
        end
        sent_so_far = sum[23:0];
        return ST_PROGRESS;
    endfunction

    function automatic out_word_t queue_step(input in_word_t w);
        out_word_t r;
        int ev;
        ev = 0;
        if (w.command == CMD_GENERIC || w.command == CMD_MEDIA)
        begin
            if (w.packet_length == 0 || !link_up)
                r.status = ST_DROPPED;
            else if (w.command == CMD_GENERIC)
                r.status = (w.depth_limit == 0) ? ST_DROPPED : queue_generic(w, ev);
            else
                r.status = queue_media(w, ev);
        end
        else if (w.command == CMD_REPORT)
            r.status = link_up ? take_report(w.sent_bytes) : ST_FAIL;
        else
            r.status = ST_DROPPED;
        if (slots.size() > 0)
        begin
            r.head_handle = slots[0].handle;
            r.head_length = slots[0].length;
            r.head_offset = sent_so_far;
        end
        else
        begin
            r.head_handle = '0;
            r.head_length = '0;
            r.head_offset = '0;
        end
        r.queue_count = 8'(slots.size());
        r.evicted_count = 8'(ev);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            slots.delete();
            replies.delete();
            sent_so_far = '0;
            waiting_key = 1'b1;
            link_up = 1'b0;
            media_on = 1'b0;
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            // result strobe is checked against predictions made on earlier edges
            if (done)
            begin
                result_count++;
                if (replies.size() == 0)
                begin
                    report_mismatch("unexpected result word", 32'd1, 32'd0);
                end
                else
                begin
                    want = replies[0];
                    replies.delete(0);
                    if (out_word.status != want.status)
                        report_mismatch("status", out_word.status, want.status);
                    if (out_word.head_handle != want.head_handle)
                        report_mismatch("head_handle", out_word.head_handle,
                                        want.head_handle);
                    if (out_word.head_length != want.head_length)
                        report_mismatch("head_length", out_word.head_length,
                                        want.head_length);
                    if (out_word.head_offset != want.head_offset)
                        report_mismatch("head_offset", out_word.head_offset,
                                        want.head_offset);
                    if (out_word.queue_count != want.queue_count)
                        report_mismatch("queue_count", out_word.queue_count,
                                        want.queue_count);
                    if (out_word.evicted_count != want.evicted_count)
                        report_mismatch("evicted_count", out_word.evicted_count,
                                        want.evicted_count);
                end
            end
            if (start && !busy)
                replies.insert(replies.size(), queue_step(in_word));
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == REG_MEDIA_MODE)
                    media_on = pwdata[0];
                else
                    link_up = pwdata[0];
            end
        end
    end
endmodule

@@ test/testbench.sv @@
module testbench;
    import dpsq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_word_t    in_word;
    logic        done;
    out_word_t   out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          idle_cycles = 0;
    int          sent_words;
    bit          calm;

    droppable_packet_send_queue u_dut (.*);

    dpsq_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog: cycles with nothing accepted
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("watchdog expired");
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic v);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {$urandom} & 32'hFFFF_FFFE | v;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_word(input in_word_t w);
        if (!calm && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 14)) @(negedge clk);
        in_word = w;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start = 1'b0;
        sent_words++;
    endtask

    task automatic drain();
        while (pending_count > 0)
            @(negedge clk);
        // evictions all finish before the word's result strobe, so none are left once no result is pending
        repeat (300) @(negedge clk);
    endtask

    function automatic in_word_t rand_word(input int profile);
        in_word_t w;
        logic [95:0] rnd;
        rnd = {$urandom, $urandom, $urandom};
        w = rnd[$bits(in_word_t)-1:0];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w.command = CMD_GENERIC;
            4, 5, 6:    w.command = CMD_MEDIA;
            7, 8:       w.command = CMD_REPORT;
            default:    w.command = CMD_UNUSED;
        endcase
        if ($urandom_range(0, 3) != 0)
            w.packet_length = 24'($urandom_range(1, 3000));
        if ($urandom_range(0, 30) == 0)
            w.packet_length = 0;
        if (profile == 0)
            w.depth_limit = 8'($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                          : $urandom_range(1, 128));
        else
            w.depth_limit = 8'($urandom_range(110, 140));
        if ($urandom_range(0, 3) != 0)
            w.sent_bytes = 24'($urandom_range(0, 2000));
        if (profile == 1 && w.command == CMD_REPORT && $urandom_range(0, 1) == 0)
            w.command = CMD_GENERIC;
        return w;
    endfunction

    initial
    begin
        in_word_t w;
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sent_words = 0;
        calm = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // link closed: everything drops or fails
        calm = 1'b1;
        w = '0;
        w.packet_length = 24'd10;
        w.depth_limit = 8'd4;
        send_word(w);
        w.command = CMD_REPORT;
        w.sent_bytes = 24'd5;
        send_word(w);
        drain();
        write_reg(REG_LINK_OPEN, 1'b1);

        // directed: extremes and special cases
        w = '0;
        w.command = CMD_REPORT;
        w.sent_bytes = 24'hFFFFFF;
        send_word(w);
        w = '0;
        w.packet_length = 24'hFFFFFF;
        w.packet_handle = 16'hFFFF;
        w.depth_limit = 8'd128;
        send_word(w);
        w.depth_limit = 8'd0;
        send_word(w);
        w.depth_limit = 8'd255;
        w.packet_length = 24'd0;
        send_word(w);
        w = '0;
        w.command = CMD_REPORT;
        send_word(w);
        w.sent_bytes = 24'd1;
        send_word(w);
        w.sent_bytes = 24'hFFFFFF;
        send_word(w);
        w = '0;
        w.command = CMD_UNUSED;
        w.packet_length = 24'd5;
        send_word(w);
        w = '0;
        w.command = CMD_MEDIA;
        w.packet_length = 24'd9;
        w.key_pkt = 1'b1;
        send_word(w);
        drain();
        write_reg(REG_MEDIA_MODE, 1'b1);
        w.key_pkt = 1'b0;
        send_word(w);
        w.cfg_pkt = 1'b1;
        send_word(w);
        w.cfg_pkt = 1'b0;
        w.key_pkt = 1'b1;
        send_word(w);
        w.key_pkt = 1'b0;
        send_word(w);
        // droppable with depth 1 that finds nothing to evict
        w = '0;
        w.packet_length = 24'd7;
        w.droppable = 1'b1;
        w.depth_limit = 8'd1;
        send_word(w);
        drain();

        // random: phases cycle through register settings
        calm = 1'b0;
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                calm = 1'b1;
            for (int i = 0; i < 150; i++)
                send_word(rand_word(ph % 3 == 1 ? 1 : 0));
            drain();
            write_reg(REG_LINK_OPEN, ph != 2);
            write_reg(REG_MEDIA_MODE, ph[0]);
        end
        drain();

        $display("sent %0d command words, checked %0d result words", sent_words,
                 result_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
